// ----- rtl/m4ma_pkg.sv -----
// ----------------------------------------------------------------------------
// m4ma_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiply/add unit.
// ----------------------------------------------------------------------------
package m4ma_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'b1;

    localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sh0001_0000;

    typedef enum logic [1:0] {
        OP_MUL   = 2'd0,
        OP_ADD   = 2'd1,
        OP_SCALE = 2'd2,
        OP_MAC   = 2'd3
    } op_t;

    // What one term in the datapath does
    typedef enum logic [1:0] {
        K_MUL_RIGHT = 2'd0,
        K_MUL_SCALE = 2'd1,
        K_ADD_RIGHT = 2'd2,
        K_PASS_LEFT = 2'd3
    } term_kind_t;

    typedef struct packed {
        logic       issue;
        logic       first;
        logic       last;
        logic       final_elem;
        term_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic result_taken;
    } status_t;

endpackage

// ----- rtl/m4ma_ctrl.sv -----
// ----------------------------------------------------------------------------
// m4ma_ctrl
// Sequencer: counts loaded pairs, then walks the result elements and issues
// one term per cycle to the datapath, then waits until each result is taken.
// ----------------------------------------------------------------------------
module m4ma_ctrl #(
    parameter int DIM = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  m4ma_pkg::op_t                     operation,
    input  logic                              in_accept,
    output logic                              load_ready,
    output logic [$clog2(DIM*DIM)-1:0]        wr_addr,
    output m4ma_pkg::cmd_t                    cmd,
    output logic [$clog2(DIM*DIM)-1:0]        l_addr,
    output logic [$clog2(DIM*DIM)-1:0]        r_addr,
    input  m4ma_pkg::status_t                 status
);
    import m4ma_pkg::*;

    localparam int ELEMS  = DIM * DIM;
    localparam int ADDR_W = $clog2(ELEMS);
    localparam int RC_W   = $clog2(DIM);
    localparam int K_W    = $clog2(DIM + 2);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] load_cnt_reg;
    logic [RC_W-1:0]   row_reg;
    logic [RC_W-1:0]   col_reg;
    logic [K_W-1:0]    k_reg;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] l_addr_reg;
    logic [ADDR_W-1:0] r_addr_reg;

    logic [K_W-1:0]    last_k;
    logic [ADDR_W-1:0] elem_addr;
    logic [ADDR_W-1:0] row_k_addr;
    logic [ADDR_W-1:0] k_col_addr;
    logic              final_elem;

    always_comb
    begin
        case (operation)
            OP_MUL:  last_k = K_W'(DIM - 1);
            OP_MAC:  last_k = K_W'(DIM);
            default: last_k = '0;
        endcase
    end

    assign elem_addr  = ADDR_W'(row_reg) * ADDR_W'(DIM) + ADDR_W'(col_reg);
    assign row_k_addr = ADDR_W'(row_reg) * ADDR_W'(DIM) + ADDR_W'(k_reg);
    assign k_col_addr = ADDR_W'(k_reg) * ADDR_W'(DIM) + ADDR_W'(col_reg);
    assign final_elem = (row_reg == RC_W'(DIM - 1)) && (col_reg == RC_W'(DIM - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
            cmd_reg      <= '0;
            l_addr_reg   <= '0;
            r_addr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    cmd_reg.issue <= 1'b0;
                    if (in_accept)
                    begin
                        if (load_cnt_reg == ADDR_W'(ELEMS - 1))
                        begin
                            load_cnt_reg <= '0;
                            row_reg      <= '0;
                            col_reg      <= '0;
                            k_reg        <= '0;
                            state_reg    <= ST_ISSUE;
                        end
                        else
                        begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    cmd_reg.issue      <= 1'b1;
                    cmd_reg.first      <= (k_reg == '0);
                    cmd_reg.last       <= (k_reg == last_k);
                    cmd_reg.final_elem <= final_elem;
                    case (operation)
                        OP_ADD:
                        begin
                            cmd_reg.kind <= K_ADD_RIGHT;
                            l_addr_reg   <= elem_addr;
                            r_addr_reg   <= elem_addr;
                        end
                        OP_SCALE:
                        begin
                            cmd_reg.kind <= K_MUL_SCALE;
                            l_addr_reg   <= elem_addr;
                            r_addr_reg   <= elem_addr;
                        end
                        default:
                        begin
                            if (k_reg == K_W'(DIM))
                            begin
                                // fused mode: final term adds the left element
                                cmd_reg.kind <= K_PASS_LEFT;
                                l_addr_reg   <= elem_addr;
                                r_addr_reg   <= elem_addr;
                            end
                            else
                            begin
                                cmd_reg.kind <= K_MUL_RIGHT;
                                l_addr_reg   <= row_k_addr;
                                r_addr_reg   <= k_col_addr;
                            end
                        end
                    endcase
                    if (k_reg == last_k)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    cmd_reg.issue <= 1'b0;
                    if (status.result_taken)
                    begin
                        if (final_elem)
                        begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            if (col_reg == RC_W'(DIM - 1))
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + 1'b1;
                            end
                            else
                            begin
                                col_reg <= col_reg + 1'b1;
                            end
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    cmd_reg.issue <= 1'b0;
                    state_reg     <= ST_LOAD;
                end
            endcase
        end
    end

    assign load_ready = (state_reg == ST_LOAD);
    assign wr_addr    = load_cnt_reg;
    assign cmd        = cmd_reg;
    assign l_addr     = l_addr_reg;
    assign r_addr     = r_addr_reg;

    a_no_load_during_issue: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_ready && cmd_reg.issue))
        else $error("term issued while loading");

    a_count_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(load_ready) |-> (load_cnt_reg == '0))
        else $error("load count not cleared at end of load");

endmodule

// ----- rtl/m4ma_dp.sv -----
// ----------------------------------------------------------------------------
// m4ma_dp
// Datapath: operand stores, shared multiplier, wide accumulator, saturation
// and the output register.
// ----------------------------------------------------------------------------
module m4ma_dp #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     wr_en,
    input  logic [$clog2(DIM*DIM)-1:0]               wr_addr,
    input  logic signed [m4ma_pkg::DATA_W-1:0]       left_value,
    input  logic signed [m4ma_pkg::DATA_W-1:0]       right_value,
    input  m4ma_pkg::cmd_t                           cmd,
    input  logic [$clog2(DIM*DIM)-1:0]               l_addr,
    input  logic [$clog2(DIM*DIM)-1:0]               r_addr,
    input  logic signed [m4ma_pkg::DATA_W-1:0]       scale_factor,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic signed [m4ma_pkg::DATA_W-1:0]       result_value,
    output logic                                     last_element,
    output m4ma_pkg::status_t                        status
);
    import m4ma_pkg::*;

    localparam int ELEMS = DIM * DIM;
    localparam int ACC_W = PROD_W - FRAC_BITS + $clog2(DIM + 1) + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    logic signed [DATA_W-1:0] left_mem  [ELEMS];
    logic signed [DATA_W-1:0] right_mem [ELEMS];

    cmd_t                     cmd_a_reg;
    cmd_t                     cmd_b_reg;
    logic signed [DATA_W-1:0] l_rd_reg;
    logic signed [DATA_W-1:0] r_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] result_reg;
    logic                     last_reg;

    logic signed [DATA_W-1:0] b_op;
    logic signed [PROD_W-1:0] mul_full;
    logic signed [PROD_W-1:0] sum_ext;
    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [DATA_W-1:0] sat_val;

    // Operand stores
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= left_value;
            right_mem[wr_addr] <= right_value;
        end
        if (cmd.issue)
        begin
            l_rd_reg <= left_mem[l_addr];
            r_rd_reg <= right_mem[r_addr];
        end
    end

    assign b_op     = (cmd_a_reg.kind == K_MUL_SCALE) ? scale_factor : r_rd_reg;
    assign mul_full = l_rd_reg * b_op;
    assign sum_ext  = PROD_W'(l_rd_reg) +
                      ((cmd_a_reg.kind == K_ADD_RIGHT) ? PROD_W'(r_rd_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (cmd_a_reg.issue)
        begin
            if (cmd_a_reg.kind == K_MUL_RIGHT || cmd_a_reg.kind == K_MUL_SCALE)
                prod_reg <= mul_full;
            else
                prod_reg <= sum_ext;
        end
    end

    // Arithmetic shift floors toward minus infinity
    assign shifted  = prod_reg >>> FRAC_BITS;
    assign term     = (cmd_b_reg.kind == K_MUL_RIGHT || cmd_b_reg.kind == K_MUL_SCALE)
                      ? shifted : prod_reg;
    assign acc_next = (cmd_b_reg.first ? '0 : acc_reg) + $signed(term[ACC_W-1:0]);

    always_comb
    begin
        if (acc_next > SAT_MAX)
            sat_val = SAT_MAX[DATA_W-1:0];
        else if (acc_next < SAT_MIN)
            sat_val = SAT_MIN[DATA_W-1:0];
        else
            sat_val = acc_next[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_b_reg.issue)
        begin
            acc_reg <= acc_next;
            if (cmd_b_reg.last)
            begin
                result_reg <= sat_val;
                last_reg   <= cmd_b_reg.final_elem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_a_reg     <= '0;
            cmd_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_a_reg <= cmd;
            cmd_b_reg <= cmd_a_reg;
            if (cmd_b_reg.issue && cmd_b_reg.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid           = out_valid_reg;
    assign result_value        = result_reg;
    assign last_element        = last_reg;
    assign status.result_taken = out_valid_reg && out_ready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_b_reg.issue && cmd_b_reg.last) |-> !out_valid_reg)
        else $error("result overwritten before it was taken");

    a_element_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_a_reg.issue && cmd_a_reg.first) |-> (!cmd_b_reg.issue || cmd_b_reg.last))
        else $error("new element started before previous one finished");

endmodule

// ----- rtl/matrix4_multiply_add_unit.sv -----
// ----------------------------------------------------------------------------
// matrix4_multiply_add_unit
// Signed fixed-point DIM x DIM matrix multiply / add / scale / multiply-add.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): send DIM*DIM element pairs of the left
//   and right matrices in row-major order, one request per pair. in_ready is
//   high only while loading; a pair that is not the last one yields no result.
//   Output channel (out_valid/out_ready): after the last pair the unit emits
//   DIM*DIM result elements in row-major order, last_element marking the
//   final one. Results are signed Q(32-FRAC_BITS).FRAC_BITS, saturated.
//   Configuration channel (cfg_valid/cfg_ready, always ready): index 0 is the
//   operation (multiply, add, scale left, multiply then add left), index 1
//   the scale factor. Write it only while no run is in progress.
// Flow:
//   in_ready stays high for the whole load, so pairs can arrive back to back.
//   Each result element is then summed from its terms (DIM in multiply mode,
//   DIM+1 in fused mode, one in add and scale modes), issued back to back
//   through three pipeline stages (operand read, shared multiplier,
//   accumulator) into the output register. The next element starts only
//   once the result is taken, so elements never overlap in the pipeline.
// Reset clears the sequencer, load count, pipeline control and output valid, and
//   sets operation to multiply and scale factor to 1.0; the operand stores are
//   not cleared. When out_ready is low the result holds and the sequencer waits.
// ----------------------------------------------------------------------------
module matrix4_multiply_add_unit #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [m4ma_pkg::DATA_W-1:0]       left_value,
    input  logic signed [m4ma_pkg::DATA_W-1:0]       right_value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [m4ma_pkg::DATA_W-1:0]       result_value,
    output logic                                     last_element,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [m4ma_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [m4ma_pkg::DATA_W-1:0]              cfg_data
);
    import m4ma_pkg::*;

    localparam int ADDR_W = $clog2(DIM * DIM);

    op_t                      operation_reg;
    logic signed [DATA_W-1:0] scale_reg;

    logic                     in_accept;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        l_addr;
    logic [ADDR_W-1:0]        r_addr;
    cmd_t                     cmd;
    status_t                  status;

    // Configuration registers: take a write every cycle it is offered
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= OP_MUL;
            scale_reg     <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OPERATION: operation_reg <= op_t'(cfg_data[1:0]);
                REG_SCALE:     scale_reg     <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // Accepted input pair: write the operand stores and advance the count
    assign in_accept = in_valid && in_ready;

    m4ma_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation_reg),
        .in_accept  (in_accept),
        .load_ready (in_ready),
        .wr_addr    (wr_addr),
        .cmd        (cmd),
        .l_addr     (l_addr),
        .r_addr     (r_addr),
        .status     (status)
    );

    m4ma_dp #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (in_accept),
        .wr_addr      (wr_addr),
        .left_value   (left_value),
        .right_value  (right_value),
        .cmd          (cmd),
        .l_addr       (l_addr),
        .r_addr       (r_addr),
        .scale_factor (scale_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_value (result_value),
        .last_element (last_element),
        .status       (status)
    );

endmodule
